FILE: hw/rtl/i2c_master_transfer_sequencer_unit_macros.svh
// Assertion macros shared by the RTL files of the I2C transfer sequencer.
// No dependencies; files that assert include this header by name.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CSEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cseq same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2CSEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cseq next-cycle check failed");

`endif

FILE: hw/rtl/i2cseq_pkg.sv
// Types, codes and defaults for the I2C write-then-read transfer sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cseq_pkg;

    // Default parameter values.
    localparam int DEF_MAX_TRANSFER_BYTES = 255;
    localparam int DEF_COUNTER_WIDTH      = 16;

    // Largest count an 8-bit count field can carry.
    localparam int COUNT_FIELD_MAX = 255;

    // Configuration port geometry and reset values.
    localparam int          CFG_ADDR_W      = 3;
    localparam int          CFG_DATA_W      = 32;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [2:0]  MAX_TRIES_RESET = 3'd3;
    localparam logic [2:0]  TRIES_SAT       = 3'd7;
    localparam logic [15:0] TICK_SAT        = 16'hFFFF;

    // Register index codes (word address bit 2).
    localparam logic REG_TIMEOUT   = 1'b0;
    localparam logic REG_MAX_TRIES = 1'b1;

    // Input item kinds.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_EVENT = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Ten-bit read restart header: 11110, address bits 9..8, read bit.
    localparam logic [4:0] TEN_BIT_HEADER = 5'b11110;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WRITING,
        PH_TENBIT_READ,
        PH_READING,
        PH_RETRY_WAIT
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD_ADDR,
        ACT_SEND,
        ACT_STOP,
        ACT_ACK,
        ACT_NAK_STOP
    } action_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_BUS,
        ERR_NAK,
        ERR_OTHER,
        ERR_TIMEOUT
    } err_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [2:0]  max_tries;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] target_address;
        logic [7:0] write_count;
        logic [7:0] read_count;
        logic       flag_master_on_bus;
        logic       flag_slave_on_bus;
        logic       flag_error;
        logic       status_bus_error;
        logic       status_arbitration_lost;
        logic       status_rx_nack;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [10:0] addr_value;
        logic        ten_bit_enable;
        logic [7:0]  tx_data;
        logic [7:0]  rx_data;
        logic        rx_valid;
        logic        transfer_done;
        logic        transfer_ok;
        err_t        error_kind;
        logic [15:0] bus_error_total;
        logic [15:0] nak_total;
        logic [15:0] other_error_total;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_master_transfer_sequencer_unit.sv
// Top level of the I2C write-then-read transfer sequencer: input register,
// result register and configuration port. Depends on i2cseq_pkg, i2cseq_cfg
// and i2cseq_core.
//
//  Channel  Handshake           Content
//  in       in_valid/in_stall   start, bus event or tick with its fields
//  out      out_valid/out_stall one result per accepted item
//  cfg      psel/penable/pready timeout_ticks at 0x0, max_tries at 0x4
//
// An accepted item sits in the input register while the decision logic works
// on it, and the result register loads when the item advances, which waits
// while an offered result is held by out_stall.
// One item per cycle is sustained while out_stall is low.
// in_stall is high only while the input register holds a request and a result
// waits with out_stall high. Reset clears state and counters, restores config.
`default_nettype none

module i2c_master_transfer_sequencer_unit
    import i2cseq_pkg::*;
#(
    parameter int MAX_TRANSFER_BYTES = DEF_MAX_TRANSFER_BYTES,
    parameter int COUNTER_WIDTH      = DEF_COUNTER_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // Input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            func,
    input  wire logic [9:0]            target_address,
    input  wire logic [7:0]            write_count,
    input  wire logic [7:0]            read_count,
    input  wire logic                  flag_master_on_bus,
    input  wire logic                  flag_slave_on_bus,
    input  wire logic                  flag_error,
    input  wire logic                  status_bus_error,
    input  wire logic                  status_arbitration_lost,
    input  wire logic                  status_rx_nack,
    input  wire logic [7:0]            rx_byte,
    input  wire logic [7:0]            tx_byte,
    // Output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [2:0]            action,
    output logic      [10:0]           addr_value,
    output logic                       ten_bit_enable,
    output logic      [7:0]            tx_data,
    output logic      [7:0]            rx_data,
    output logic                       rx_valid,
    output logic                       transfer_done,
    output logic                       transfer_ok,
    output logic      [2:0]            error_kind,
    output logic      [15:0]           bus_error_total,
    output logic      [15:0]           nak_total,
    output logic      [15:0]           other_error_total
);

    cfg_t  cfg;
    item_t item_in;
    item_t item_reg;
    logic  in_valid_reg, in_valid_next;
    logic  out_valid_reg, out_valid_next;
    res_t  res_comb;
    res_t  res_reg;
    logic  advance;
    logic  take_in;

    i2cseq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Gather the input request.
    assign item_in.func                    = func;
    assign item_in.target_address          = target_address;
    assign item_in.write_count             = write_count;
    assign item_in.read_count              = read_count;
    assign item_in.flag_master_on_bus      = flag_master_on_bus;
    assign item_in.flag_slave_on_bus       = flag_slave_on_bus;
    assign item_in.flag_error              = flag_error;
    assign item_in.status_bus_error        = status_bus_error;
    assign item_in.status_arbitration_lost = status_arbitration_lost;
    assign item_in.status_rx_nack          = status_rx_nack;
    assign item_in.rx_byte                 = rx_byte;
    assign item_in.tx_byte                 = tx_byte;

    // Flow control: the held item moves on when the result slot is free.
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign take_in        = in_valid && !in_stall;
    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    i2cseq_core #(
        .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES),
        .COUNTER_WIDTH      (COUNTER_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
            item_reg <= item_in;
        if (advance)
            res_reg <= res_comb;
    end

    // Result fields.
    assign out_valid         = out_valid_reg;
    assign action            = res_reg.action;
    assign addr_value        = res_reg.addr_value;
    assign ten_bit_enable    = res_reg.ten_bit_enable;
    assign tx_data           = res_reg.tx_data;
    assign rx_data           = res_reg.rx_data;
    assign rx_valid          = res_reg.rx_valid;
    assign transfer_done     = res_reg.transfer_done;
    assign transfer_ok       = res_reg.transfer_ok;
    assign error_kind        = res_reg.error_kind;
    assign bus_error_total   = res_reg.bus_error_total;
    assign nak_total         = res_reg.nak_total;
    assign other_error_total = res_reg.other_error_total;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cseq_cfg.sv
// APB-style configuration registers: timeout in ticks and the try limit.
// Depends on i2cseq_pkg.
`default_nettype none

module i2cseq_cfg
    import i2cseq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [15:0] timeout_reg;
    logic [15:0] timeout_next;
    logic [2:0]  max_tries_reg;
    logic [2:0]  max_tries_next;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Write decode.
    always_comb
    begin
        timeout_next   = timeout_reg;
        max_tries_next = max_tries_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_TIMEOUT:   timeout_next   = pwdata[15:0];
                REG_MAX_TRIES: max_tries_next = pwdata[2:0];
                default:       timeout_next   = timeout_reg;
            endcase
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_sel)
            REG_TIMEOUT:   prdata = CFG_DATA_W'(timeout_reg);
            REG_MAX_TRIES: prdata = CFG_DATA_W'(max_tries_reg);
            default:       prdata = '0;
        endcase
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            max_tries_reg <= MAX_TRIES_RESET;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            max_tries_reg <= max_tries_next;
        end
    end

    assign cfg.timeout_ticks = timeout_reg;
    assign cfg.max_tries     = max_tries_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cseq_core.sv
// Transfer state machine, byte counters, retry and timeout logic, and the
// saturating error counters. Depends on i2cseq_pkg and the macros header.
`default_nettype none
`include "i2c_master_transfer_sequencer_unit_macros.svh"

module i2cseq_core
    import i2cseq_pkg::*;
#(
    parameter int MAX_TRANSFER_BYTES = DEF_MAX_TRANSFER_BYTES,
    parameter int COUNTER_WIDTH      = DEF_COUNTER_WIDTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output res_t       result
);

    localparam int          CLAMP_INT   = (MAX_TRANSFER_BYTES > COUNT_FIELD_MAX) ?
                                          COUNT_FIELD_MAX : MAX_TRANSFER_BYTES;
    localparam logic [7:0]  COUNT_CLAMP = 8'(CLAMP_INT);

    phase_t                   phase_reg, phase_next;
    logic [10:0]              sa_reg, sa_next;
    logic [7:0]               wl_reg, wl_next;
    logic [7:0]               rl_reg, rl_next;
    logic [7:0]               swc_reg, swc_next;
    logic [7:0]               src_reg, src_next;
    logic [2:0]               tries_reg, tries_next;
    logic [15:0]              tick_reg, tick_next;
    logic [COUNTER_WIDTH-1:0] bus_cnt_reg, bus_cnt_next;
    logic [COUNTER_WIDTH-1:0] nak_cnt_reg, nak_cnt_next;
    logic [COUNTER_WIDTH-1:0] oth_cnt_reg, oth_cnt_next;

    logic        is_start, is_event, is_tick, active;
    logic        master_only, slave_only;
    logic        start_idle, start_empty, begin_go;
    logic [7:0]  new_wc, new_rc;
    logic [10:0] new_sa;
    logic [7:0]  begin_wc, begin_rc;
    logic [10:0] begin_sa;
    logic        begin_ten, cur_ten;
    phase_t      begin_phase;
    logic        ev_bad, ev_good_w, ev_good_t, ev_good_r;
    logic [15:0] tick_inc;
    logic        timed_out, fail;
    logic [2:0]  tries_inc;
    logic        last_try;
    logic [7:0]  rl_dec;
    logic [10:0] restart_addr;
    logic        bus_kind, nak_kind;
    logic [31:0] bus_wide, nak_wide, oth_wide;
    logic        rx_act_ok;

    function automatic logic [7:0] clamp_count(input logic [7:0] v);
        return (v > COUNT_CLAMP) ? COUNT_CLAMP : v;
    endfunction

    function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Item decode.
    assign is_start    = (item.func == FUNC_START);
    assign is_event    = (item.func == FUNC_EVENT);
    assign is_tick     = (item.func == FUNC_TICK);
    assign active      = (phase_reg == PH_WRITING) || (phase_reg == PH_TENBIT_READ) ||
                         (phase_reg == PH_READING);
    assign master_only = item.flag_master_on_bus && !item.flag_slave_on_bus &&
                         !item.flag_error;
    assign slave_only  = !item.flag_master_on_bus && item.flag_slave_on_bus &&
                         !item.flag_error;

    // Start of a transfer and start of an attempt.
    assign new_wc      = clamp_count(item.write_count);
    assign new_rc      = clamp_count(item.read_count);
    assign new_sa      = {item.target_address, 1'b0};
    assign start_idle  = is_start && (phase_reg == PH_IDLE);
    assign start_empty = start_idle && (new_wc == 8'd0) && (new_rc == 8'd0);
    assign begin_go    = (start_idle && !start_empty) ||
                         (is_tick && (phase_reg == PH_RETRY_WAIT));
    assign begin_wc    = start_idle ? new_wc : swc_reg;
    assign begin_rc    = start_idle ? new_rc : src_reg;
    assign begin_sa    = start_idle ? new_sa : sa_reg;
    assign begin_ten   = |begin_sa[10:8];
    assign begin_phase = (begin_wc != 8'd0) ? PH_WRITING :
                         (begin_ten ? PH_TENBIT_READ : PH_READING);

    // Bus event classification.
    assign ev_bad    = is_event &&
                       ((((phase_reg == PH_WRITING) || (phase_reg == PH_TENBIT_READ)) &&
                         !master_only) ||
                        ((phase_reg == PH_READING) && !slave_only));
    assign ev_good_w = is_event && (phase_reg == PH_WRITING) && master_only;
    assign ev_good_t = is_event && (phase_reg == PH_TENBIT_READ) && master_only;
    assign ev_good_r = is_event && (phase_reg == PH_READING) && slave_only;
    assign bus_kind  = item.status_bus_error || item.status_arbitration_lost;
    assign nak_kind  = item.status_rx_nack;

    // Timeout and try accounting.
    assign tick_inc  = (tick_reg == TICK_SAT) ? tick_reg : tick_reg + 16'd1;
    assign timed_out = is_tick && active && (tick_inc >= cfg.timeout_ticks);
    assign fail      = ev_bad || timed_out;
    assign tries_inc = (tries_reg == TRIES_SAT) ? tries_reg : tries_reg + 3'd1;
    assign last_try  = (tries_inc >= cfg.max_tries);

    // Read-part address: the ten-bit form restarts with the short header.
    assign cur_ten      = |sa_reg[10:8];
    assign restart_addr = cur_ten ? {3'b000, TEN_BIT_HEADER, sa_reg[10:9], 1'b1} :
                                    (sa_reg | 11'd1);
    assign rl_dec       = (rl_reg != 8'd0) ? rl_reg - 8'd1 : rl_reg;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (begin_go)
        begin
            phase_next = begin_phase;
        end
        else if (fail)
        begin
            phase_next = last_try ? PH_IDLE : PH_RETRY_WAIT;
        end
        else
        begin
            unique case (phase_reg)
                PH_WRITING:
                begin
                    if (ev_good_w && (wl_reg == 8'd0))
                        phase_next = (rl_reg == 8'd0) ? PH_IDLE : PH_READING;
                end
                PH_TENBIT_READ:
                begin
                    if (ev_good_t)
                        phase_next = PH_READING;
                end
                PH_READING:
                begin
                    if (ev_good_r && (rl_dec == 8'd0))
                        phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result and datapath updates.
    always_comb
    begin
        result       = '0;
        sa_next      = sa_reg;
        wl_next      = wl_reg;
        rl_next      = rl_reg;
        swc_next     = swc_reg;
        src_next     = src_reg;
        tries_next   = tries_reg;
        tick_next    = tick_reg;
        bus_cnt_next = bus_cnt_reg;
        nak_cnt_next = nak_cnt_reg;
        oth_cnt_next = oth_cnt_reg;

        if (start_idle)
        begin
            swc_next   = new_wc;
            src_next   = new_rc;
            sa_next    = new_sa;
            tries_next = 3'd0;
        end

        if (start_empty)
        begin
            wl_next              = 8'd0;
            rl_next              = 8'd0;
            result.transfer_done = 1'b1;
            result.transfer_ok   = 1'b1;
        end

        if (begin_go)
        begin
            wl_next               = begin_wc;
            rl_next               = begin_rc;
            tick_next             = 16'd0;
            result.action         = ACT_LOAD_ADDR;
            result.ten_bit_enable = begin_ten;
            result.addr_value     = ((begin_wc == 8'd0) && !begin_ten) ?
                                    (begin_sa | 11'd1) : begin_sa;
        end

        if (is_tick && active)
        begin
            tick_next = tick_inc;
        end

        // A failed attempt: bad events are classified and counted, timeouts are not counted.
        if (fail)
        begin
            tries_next = tries_inc;
            if (last_try)
                result.transfer_done = 1'b1;
            if (ev_bad)
            begin
                result.action = ACT_STOP;
                if (bus_kind)
                begin
                    bus_cnt_next      = sat_inc(bus_cnt_reg);
                    result.error_kind = ERR_BUS;
                end
                else if (nak_kind)
                begin
                    nak_cnt_next      = sat_inc(nak_cnt_reg);
                    result.error_kind = ERR_NAK;
                end
                else
                begin
                    oth_cnt_next      = sat_inc(oth_cnt_reg);
                    result.error_kind = ERR_OTHER;
                end
            end
            else
            begin
                result.error_kind = ERR_TIMEOUT;
            end
        end

        // Write part: send bytes, then stop or restart for the read part.
        if (ev_good_w)
        begin
            if (wl_reg != 8'd0)
            begin
                wl_next        = wl_reg - 8'd1;
                result.action  = ACT_SEND;
                result.tx_data = item.tx_byte;
            end
            else if (rl_reg == 8'd0)
            begin
                result.action        = ACT_STOP;
                result.transfer_done = 1'b1;
                result.transfer_ok   = 1'b1;
            end
            else
            begin
                result.action     = ACT_LOAD_ADDR;
                result.addr_value = restart_addr;
            end
        end

        if (ev_good_t)
        begin
            result.action     = ACT_LOAD_ADDR;
            result.addr_value = restart_addr;
        end

        // Read part: ack each byte, nak and stop on the last.
        if (ev_good_r)
        begin
            rl_next         = rl_dec;
            result.rx_data  = item.rx_byte;
            result.rx_valid = 1'b1;
            if (rl_dec == 8'd0)
            begin
                result.action        = ACT_NAK_STOP;
                result.transfer_done = 1'b1;
                result.transfer_ok   = 1'b1;
            end
            else
            begin
                result.action = ACT_ACK;
            end
        end

        result.bus_error_total   = bus_wide[15:0];
        result.nak_total         = nak_wide[15:0];
        result.other_error_total = oth_wide[15:0];
    end

    assign bus_wide = 32'(bus_cnt_next);
    assign nak_wide = 32'(nak_cnt_next);
    assign oth_wide = 32'(oth_cnt_next);

    // State registers advance only when an item is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            sa_reg      <= '0;
            wl_reg      <= '0;
            rl_reg      <= '0;
            swc_reg     <= '0;
            src_reg     <= '0;
            tries_reg   <= '0;
            tick_reg    <= '0;
            bus_cnt_reg <= '0;
            nak_cnt_reg <= '0;
            oth_cnt_reg <= '0;
        end
        else if (en)
        begin
            phase_reg   <= phase_next;
            sa_reg      <= sa_next;
            wl_reg      <= wl_next;
            rl_reg      <= rl_next;
            swc_reg     <= swc_next;
            src_reg     <= src_next;
            tries_reg   <= tries_next;
            tick_reg    <= tick_next;
            bus_cnt_reg <= bus_cnt_next;
            nak_cnt_reg <= nak_cnt_next;
            oth_cnt_reg <= oth_cnt_next;
        end
    end

    // Actions that may carry a received byte.
    assign rx_act_ok = (result.action == ACT_ACK) || (result.action == ACT_NAK_STOP);

    // A finished transfer leaves the sequencer idle.
    `I2CSEQ_ASSERT_NEXT(a_done_goes_idle, clk, rst_n, en && result.transfer_done, phase_reg == PH_IDLE)
    // A failure short of the try limit waits for a retry tick.
    `I2CSEQ_ASSERT_NEXT(a_fail_waits_retry, clk, rst_n, en && fail && !last_try, phase_reg == PH_RETRY_WAIT)
    // Received bytes are only handed over with an ack or a final nak.
    `I2CSEQ_ASSERT_IMP(a_rx_on_read_only, clk, rst_n, en && result.rx_valid, rx_act_ok)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the I2C write-then-read transfer sequencer.
// It depends on i2cseq_pkg and i2c_master_transfer_sequencer_unit. Requests
// are predicted at acceptance and checked in order against each result.
module tb_top;
    import i2cseq_pkg::*;

    // Function code that the block must ignore.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // Cycles without any handshake before the run is abandoned.
    localparam int QUIET_LIMIT = 4000;
    // Length of the long receiver hold-off.
    localparam int HOLD_OFF_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Configuration port
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Request channel
    logic  in_valid = 1'b0;
    logic  in_stall;
    item_t in_item = '0;

    // Result channel
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  action;
    logic [10:0] addr_value;
    logic        ten_bit_enable;
    logic [7:0]  tx_data;
    logic [7:0]  rx_data;
    logic        rx_valid;
    logic        transfer_done;
    logic        transfer_ok;
    logic [2:0]  error_kind;
    logic [15:0] bus_error_total;
    logic [15:0] nak_total;
    logic [15:0] other_error_total;

    // Stimulus and expectations
    item_t       pending_requests[$];
    res_t        predicted_results[$];
    int unsigned queued_total = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;

    // Predicted sequencer state and its copy of the configuration
    logic [15:0] limit_ticks = TIMEOUT_RESET;
    logic [2:0]  limit_tries = MAX_TRIES_RESET;
    phase_t      xfer_phase = PH_IDLE;
    logic [10:0] shifted_addr = '0;
    logic [7:0]  writes_left = '0;
    logic [7:0]  reads_left = '0;
    logic [7:0]  saved_writes = '0;
    logic [7:0]  saved_reads = '0;
    logic [2:0]  tries_done = '0;
    logic [15:0] tick_count = '0;
    logic [15:0] bus_err_seen = '0;
    logic [15:0] nak_seen = '0;
    logic [15:0] other_seen = '0;
    res_t        pred;

    // Driver and monitor pacing
    item_t       offered;
    int unsigned gap_left = 0;
    int unsigned in_calm_left = 0;
    bit          in_calm = 1'b0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned out_calm_left = 0;
    bit          out_calm = 1'b0;
    res_t        want;
    int unsigned quiet_cycles = 0;

    i2c_master_transfer_sequencer_unit DUT
    (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .in_valid                (in_valid),
        .in_stall                (in_stall),
        .func                    (in_item.func),
        .target_address          (in_item.target_address),
        .write_count             (in_item.write_count),
        .read_count              (in_item.read_count),
        .flag_master_on_bus      (in_item.flag_master_on_bus),
        .flag_slave_on_bus       (in_item.flag_slave_on_bus),
        .flag_error              (in_item.flag_error),
        .status_bus_error        (in_item.status_bus_error),
        .status_arbitration_lost (in_item.status_arbitration_lost),
        .status_rx_nack          (in_item.status_rx_nack),
        .rx_byte                 (in_item.rx_byte),
        .tx_byte                 (in_item.tx_byte),
        .out_valid               (out_valid),
        .out_stall               (out_stall),
        .action                  (action),
        .addr_value              (addr_value),
        .ten_bit_enable          (ten_bit_enable),
        .tx_data                 (tx_data),
        .rx_data                 (rx_data),
        .rx_valid                (rx_valid),
        .transfer_done           (transfer_done),
        .transfer_ok             (transfer_ok),
        .error_kind              (error_kind),
        .bus_error_total         (bus_error_total),
        .nak_total               (nak_total),
        .other_error_total       (other_error_total)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Prediction of the sequencer
    // ---------------------------------------------------------------

    // Address for the read part: the ten-bit header with address bits 9..8,
    // or the seven-bit address, always with the read bit set.
    function automatic logic [10:0] read_restart_address();
        if (shifted_addr >= 11'h100)
            return 11'({TEN_BIT_HEADER, shifted_addr[10:9], 1'b1});
        return shifted_addr | 11'd1;
    endfunction

    task automatic close_transfer(input logic ok);
        xfer_phase = PH_IDLE;
        pred.transfer_done = 1'b1;
        pred.transfer_ok = ok;
    endtask

    // A new attempt reloads the counts and asks for the address load.
    task automatic open_attempt();
        writes_left = saved_writes;
        reads_left = saved_reads;
        tick_count = '0;
        pred.action = ACT_LOAD_ADDR;
        if (writes_left != 0)
        begin
            xfer_phase = PH_WRITING;
            pred.addr_value = shifted_addr;
            pred.ten_bit_enable = (shifted_addr >= 11'h100);
        end
        else if (shifted_addr >= 11'h100)
        begin
            xfer_phase = PH_TENBIT_READ;
            pred.addr_value = shifted_addr;
            pred.ten_bit_enable = 1'b1;
        end
        else
        begin
            xfer_phase = PH_READING;
            pred.addr_value = shifted_addr | 11'd1;
        end
    endtask

    // The read restart is always a seven-bit mode address load.
    task automatic load_read_restart();
        xfer_phase = PH_READING;
        pred.action = ACT_LOAD_ADDR;
        pred.addr_value = read_restart_address();
        pred.ten_bit_enable = 1'b0;
    endtask

    task automatic fail_attempt(input err_t kind);
        pred.error_kind = kind;
        if (tries_done != TRIES_SAT)
            tries_done++;
        if (tries_done >= limit_tries)
            close_transfer(1'b0);
        else
            xfer_phase = PH_RETRY_WAIT;
    endtask

    // Unexpected flags: classify, count with saturation and stop.
    task automatic flag_protocol_error(input item_t req);
        pred.action = ACT_STOP;
        if (req.status_bus_error || req.status_arbitration_lost)
        begin
            if (bus_err_seen != 16'hFFFF)
                bus_err_seen++;
            fail_attempt(ERR_BUS);
        end
        else if (req.status_rx_nack)
        begin
            if (nak_seen != 16'hFFFF)
                nak_seen++;
            fail_attempt(ERR_NAK);
        end
        else
        begin
            if (other_seen != 16'hFFFF)
                other_seen++;
            fail_attempt(ERR_OTHER);
        end
    endtask

    task automatic predict_sequencer_result(input item_t req);
        logic master_only;
        logic slave_only;
        master_only = req.flag_master_on_bus && !req.flag_slave_on_bus && !req.flag_error;
        slave_only = !req.flag_master_on_bus && req.flag_slave_on_bus && !req.flag_error;
        pred = '0;
        case (req.func)
            FUNC_START:
            begin
                // A start is ignored unless the sequencer is idle. The counts
                // cannot exceed the transfer limit, so no clamping applies.
                if (xfer_phase == PH_IDLE)
                begin
                    saved_writes = req.write_count;
                    saved_reads = req.read_count;
                    shifted_addr = {req.target_address, 1'b0};
                    tries_done = '0;
                    if (saved_writes == 0 && saved_reads == 0)
                    begin
                        writes_left = '0;
                        reads_left = '0;
                        close_transfer(1'b1);
                    end
                    else
                        open_attempt();
                end
            end
            FUNC_EVENT:
            begin
                case (xfer_phase)
                    PH_WRITING:
                    begin
                        if (!master_only)
                            flag_protocol_error(req);
                        else if (writes_left != 0)
                        begin
                            writes_left--;
                            pred.action = ACT_SEND;
                            pred.tx_data = req.tx_byte;
                        end
                        else if (reads_left == 0)
                        begin
                            pred.action = ACT_STOP;
                            close_transfer(1'b1);
                        end
                        else
                            load_read_restart();
                    end
                    PH_TENBIT_READ:
                    begin
                        if (!master_only)
                            flag_protocol_error(req);
                        else
                            load_read_restart();
                    end
                    PH_READING:
                    begin
                        if (!slave_only)
                            flag_protocol_error(req);
                        else
                        begin
                            if (reads_left != 0)
                                reads_left--;
                            pred.rx_data = req.rx_byte;
                            pred.rx_valid = 1'b1;
                            if (reads_left == 0)
                            begin
                                pred.action = ACT_NAK_STOP;
                                close_transfer(1'b1);
                            end
                            else
                                pred.action = ACT_ACK;
                        end
                    end
                    default:
                        ;
                endcase
            end
            FUNC_TICK:
            begin
                // A tick starts a pending retry, or ages the running attempt.
                if (xfer_phase == PH_RETRY_WAIT)
                    open_attempt();
                else if (xfer_phase != PH_IDLE)
                begin
                    if (tick_count != TICK_SAT)
                        tick_count++;
                    if (tick_count >= limit_ticks)
                        fail_attempt(ERR_TIMEOUT);
                end
            end
            default:
                ;
        endcase
        pred.bus_error_total = bus_err_seen;
        pred.nak_total = nak_seen;
        pred.other_error_total = other_seen;
        predicted_results.push_back(pred);
    endtask

    // ---------------------------------------------------------------
    // Request construction
    // ---------------------------------------------------------------

    function automatic item_t any_request();
        item_t r;
        r.func = 2'($urandom_range(0, 3));
        r.target_address = 10'($urandom_range(0, 1023));
        r.write_count = 8'($urandom_range(0, 255));
        r.read_count = 8'($urandom_range(0, 255));
        r.flag_master_on_bus = 1'($urandom_range(0, 1));
        r.flag_slave_on_bus = 1'($urandom_range(0, 1));
        r.flag_error = 1'($urandom_range(0, 1));
        r.status_bus_error = 1'($urandom_range(0, 1));
        r.status_arbitration_lost = 1'($urandom_range(0, 1));
        r.status_rx_nack = 1'($urandom_range(0, 1));
        r.rx_byte = 8'($urandom_range(0, 255));
        r.tx_byte = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic item_t start_request(input logic [9:0] target, input logic [7:0] writes,
                                            input logic [7:0] reads);
        item_t r;
        r = any_request();
        r.func = FUNC_START;
        r.target_address = target;
        r.write_count = writes;
        r.read_count = reads;
        return r;
    endfunction

    function automatic item_t event_request(input logic mb, input logic sb, input logic er);
        item_t r;
        r = any_request();
        r.func = FUNC_EVENT;
        r.flag_master_on_bus = mb;
        r.flag_slave_on_bus = sb;
        r.flag_error = er;
        return r;
    endfunction

    function automatic item_t tick_request();
        item_t r;
        r = any_request();
        r.func = FUNC_TICK;
        return r;
    endfunction

    // Mostly short transfers, now and then one of any length.
    function automatic logic [7:0] pick_count();
        if ($urandom_range(0, 99) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 5));
    endfunction

    // Most waits are short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic offer_later(input item_t r);
        pending_requests.push_back(r);
        queued_total++;
    endtask

    // One well-formed transfer with random content: events with the flags
    // each step expects, stray ticks, and now and then a broken event that
    // is followed by the retry tick and a fresh attempt.
    task automatic queue_transfer();
        logic [9:0]  target;
        logic [7:0]  writes;
        logic [7:0]  reads;
        int unsigned masters;
        int unsigned step;
        int unsigned attempt;
        bit          faulted;
        bit          want_master;
        item_t       r;
        if ($urandom_range(0, 1) != 0)
            target = 10'($urandom_range(0, 127));
        else
            target = 10'($urandom_range(128, 1023));
        writes = pick_count();
        reads = pick_count();
        offer_later(start_request(target, writes, reads));
        if (writes == 0 && reads == 0)
            return;
        if (writes != 0)
            masters = writes + 1;
        else
            masters = (target >= 10'd128) ? 1 : 0;
        for (attempt = 0; attempt < 4; attempt++)
        begin
            faulted = 1'b0;
            for (step = 0; step < masters + reads && !faulted; step++)
            begin
                want_master = (step < masters);
                if ($urandom_range(0, 7) == 0)
                    offer_later(tick_request());
                if ($urandom_range(0, 49) == 0)
                begin
                    r = event_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)));
                    if (r.flag_master_on_bus == want_master &&
                        r.flag_slave_on_bus == !want_master && !r.flag_error)
                        r.flag_error = 1'b1;
                    faulted = 1'b1;
                end
                else
                    r = event_request(want_master, !want_master, 1'b0);
                offer_later(r);
            end
            if (!faulted)
                break;
            offer_later(tick_request());
        end
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = queued_total + count;
        while (queued_total < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                offer_later(any_request());
            else
                queue_transfer();
        end
    endtask

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------

    task automatic write_register(input logic reg_index, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Sampled on the falling edge so that the driver's updates have settled.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || predicted_results.size() != 0);
    endtask

    task automatic apply_settings(input logic [15:0] ticks, input logic [2:0] tries);
        wait_until_drained();
        write_register(REG_TIMEOUT, CFG_DATA_W'(ticks));
        write_register(REG_MAX_TRIES, CFG_DATA_W'(tries));
        limit_ticks = ticks;
        limit_tries = tries;
    endtask

    // ---------------------------------------------------------------
    // Stimulus plan
    // ---------------------------------------------------------------
    initial
    begin
        item_t r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: ignored requests, the empty transfer, seven-bit and
        // ten-bit transfers, then a transfer that fails on every try.
        offer_later(tick_request());
        offer_later(event_request(1'b1, 1'b0, 1'b0));
        r = any_request();
        r.func = FUNC_UNUSED;
        offer_later(r);
        offer_later(start_request(10'd0, 8'd0, 8'd0));
        offer_later(start_request(10'h012, 8'd1, 8'd1));
        r = event_request(1'b1, 1'b0, 1'b0);
        r.tx_byte = 8'hFF;
        offer_later(r);
        offer_later(event_request(1'b1, 1'b0, 1'b0));
        r = event_request(1'b0, 1'b1, 1'b0);
        r.rx_byte = 8'h00;
        offer_later(r);
        offer_later(start_request(10'h3FF, 8'd0, 8'd2));
        offer_later(event_request(1'b1, 1'b0, 1'b0));
        r = event_request(1'b0, 1'b1, 1'b0);
        r.rx_byte = 8'hFF;
        offer_later(r);
        offer_later(event_request(1'b0, 1'b1, 1'b0));
        offer_later(start_request(10'h080, 8'hFF, 8'hFF));
        offer_later(start_request(10'h005, 8'd1, 8'd1));
        r = event_request(1'b1, 1'b0, 1'b1);
        r.status_bus_error = 1'b0;
        r.status_arbitration_lost = 1'b1;
        offer_later(r);
        offer_later(event_request(1'b1, 1'b0, 1'b0));
        offer_later(start_request(10'h001, 8'd0, 8'd1));
        offer_later(tick_request());
        r = event_request(1'b0, 1'b1, 1'b0);
        r.status_bus_error = 1'b0;
        r.status_arbitration_lost = 1'b0;
        r.status_rx_nack = 1'b1;
        offer_later(r);
        offer_later(tick_request());
        r = event_request(1'b1, 1'b1, 1'b0);
        r.status_bus_error = 1'b0;
        r.status_arbitration_lost = 1'b0;
        r.status_rx_nack = 1'b0;
        offer_later(r);
        queue_random(280);

        // Timeout of one tick and a single try: the first tick ends a transfer.
        apply_settings(16'd1, 3'd1);
        offer_later(start_request(10'h003, 8'd1, 8'd0));
        offer_later(tick_request());
        offer_later(start_request(10'h007, 8'd0, 8'd0));
        queue_random(200);

        apply_settings(16'hFFFF, 3'd7);
        queue_random(300);

        // Zero timeout and zero tries.
        apply_settings(16'd0, 3'd0);
        offer_later(start_request(10'h009, 8'd0, 8'd1));
        offer_later(tick_request());
        offer_later(start_request(10'h200, 8'd2, 8'd0));
        r = event_request(1'b0, 1'b0, 1'b1);
        r.status_bus_error = 1'b0;
        r.status_arbitration_lost = 1'b0;
        r.status_rx_nack = 1'b0;
        offer_later(r);
        queue_random(120);

        apply_settings(16'($urandom_range(2, 20)), 3'($urandom_range(1, 7)));
        queue_random(300);

        apply_settings(16'($urandom_range(1, 65535)), 3'($urandom_range(1, 7)));
        queue_random(250);

        wait_until_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Request driver: predicts each accepted request, then offers the next.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_sequencer_result(offered);

            // Alternate between stretches without gaps and gappy stretches.
            if (in_calm_left == 0)
            begin
                in_calm = ($urandom_range(0, 3) == 0);
                in_calm_left = $urandom_range(50, 400);
            end
            else
                in_calm_left--;

            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    offered = pending_requests.pop_front();
                    in_item <= offered;
                    in_valid <= 1'b1;
                    gap_left = in_calm ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and receiver stalls
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] expected);
        $display("mismatch at result %0d, %s: got %h, expected %h",
                 results_seen, what, got, expected);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                    report_mismatch("result with no request pending", 16'(action), 16'd0);
                else
                begin
                    want = predicted_results.pop_front();
                    if (action !== want.action)
                        report_mismatch("action", 16'(action), 16'(want.action));
                    if (addr_value !== want.addr_value)
                        report_mismatch("addr_value", 16'(addr_value), 16'(want.addr_value));
                    if (ten_bit_enable !== want.ten_bit_enable)
                        report_mismatch("ten_bit_enable", 16'(ten_bit_enable),
                                        16'(want.ten_bit_enable));
                    if (tx_data !== want.tx_data)
                        report_mismatch("tx_data", 16'(tx_data), 16'(want.tx_data));
                    if (rx_data !== want.rx_data)
                        report_mismatch("rx_data", 16'(rx_data), 16'(want.rx_data));
                    if (rx_valid !== want.rx_valid)
                        report_mismatch("rx_valid", 16'(rx_valid), 16'(want.rx_valid));
                    if (transfer_done !== want.transfer_done)
                        report_mismatch("transfer_done", 16'(transfer_done),
                                        16'(want.transfer_done));
                    if (transfer_ok !== want.transfer_ok)
                        report_mismatch("transfer_ok", 16'(transfer_ok), 16'(want.transfer_ok));
                    if (error_kind !== want.error_kind)
                        report_mismatch("error_kind", 16'(error_kind), 16'(want.error_kind));
                    if (bus_error_total !== want.bus_error_total)
                        report_mismatch("bus_error_total", bus_error_total,
                                        want.bus_error_total);
                    if (nak_total !== want.nak_total)
                        report_mismatch("nak_total", nak_total, want.nak_total);
                    if (other_error_total !== want.other_error_total)
                        report_mismatch("other_error_total", other_error_total,
                                        want.other_error_total);
                end
                // Twice in the run the receiver holds off long enough for
                // the block to fill up and stall its requests.
                if (results_seen == 150 || results_seen == 1100)
                    hold_left = HOLD_OFF_CYCLES;
            end

            if (out_calm_left == 0)
            begin
                out_calm = ($urandom_range(0, 3) == 0);
                out_calm_left = $urandom_range(50, 400);
            end
            else
                out_calm_left--;

            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = out_calm ? 0 : pick_gap();
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: ends the run when no handshake happens for too long.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/i2cseq_pkg.sv
hw/rtl/i2cseq_cfg.sv
hw/rtl/i2cseq_core.sv
hw/rtl/i2c_master_transfer_sequencer_unit.sv
tb/tb_top.sv
